// File: hdl/rrf_pkg.sv
// Shared constants and types for the repeat request filter.
`default_nettype none
package rrf_pkg;
  localparam int ENTRIES = 128;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int USED_W  = $clog2(ENTRIES + 1);

  localparam logic [15:0] WINDOW_RST  = 16'd10;
  localparam logic [15:0] IP_LIM_RST  = 16'd2;
  localparam logic [15:0] MAC_LIM_RST = 16'd6;

  localparam logic [1:0] CFG_WINDOW  = 2'd0;
  localparam logic [1:0] CFG_IP_LIM  = 2'd1;
  localparam logic [1:0] CFG_MAC_LIM = 2'd2;

  typedef enum logic {PH_MATCH = 1'b0, PH_STALE = 1'b1} phase_t;

  typedef struct packed {
    logic   vld;
    phase_t phase;
    logic   hit;
    logic   rej;
  } tok_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] ip;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [15:0] window;
    logic [15:0] ip_lim;
    logic [15:0] mac_lim;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } fill_t;
endpackage
`default_nettype wire

// File: hdl/rrf_cell.sv
// One table entry with its match, age and update logic.
`default_nettype none
module rrf_cell (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire  [rrf_pkg::IDX_W-1:0]   cell_idx,
  input  wire  [rrf_pkg::USED_W-1:0]  used,
  input  rrf_pkg::req_t               req,
  input  rrf_pkg::cfg_t               cfg,
  input  rrf_pkg::fill_t              fill,
  input  rrf_pkg::tok_t               tok_i,
  output rrf_pkg::tok_t               tok_o
);
  import rrf_pkg::*;

  logic [47:0] mac_r, mac_nxt;
  logic [31:0] ip_r, ip_nxt;
  logic [31:0] time_r, time_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  tok_t        tok_r, tok_nxt;

  logic signed [32:0] age1, age2, win_s;
  logic               live, ipm, macm, rej;

  always_comb begin
    mac_nxt  = mac_r;
    ip_nxt   = ip_r;
    time_nxt = time_r;
    cnt_nxt  = cnt_r;
    tok_nxt  = tok_i;
    rej      = 1'b0;
    macm     = 1'b0;
    win_s    = {17'b0, cfg.window};
    live     = tok_i.vld && !tok_i.hit && ({1'b0, cell_idx} < used);
    age1     = {1'b0, req.now} - {1'b0, time_r};
    ipm      = (req.ip != 32'd0) && (req.ip == ip_r);
    age2     = 33'sd0;
    if (live && tok_i.phase == PH_MATCH) begin
      if (ipm) begin
        if (age1 < win_s) begin
          cnt_nxt = cnt_r + 16'd1;
          if (cnt_nxt > cfg.ip_lim) rej = 1'b1;
          else time_nxt = req.now;
        end else begin
          mac_nxt = '0; ip_nxt = '0; time_nxt = '0; cnt_nxt = '0;
        end
      end
      // MAC test sees the entry as the IP test left it
      if (!rej) begin
        macm = (req.mac != 48'd0) && (req.mac == mac_nxt);
        age2 = {1'b0, req.now} - {1'b0, time_nxt};
        if (macm) begin
          if (age2 < win_s) begin
            time_nxt = req.now;
            cnt_nxt  = cnt_nxt + 16'd1;
            if (cnt_nxt > cfg.mac_lim) rej = 1'b1;
          end else begin
            mac_nxt = '0; ip_nxt = '0; time_nxt = '0; cnt_nxt = '0;
          end
        end
      end
      tok_nxt.hit = ipm || macm;
      tok_nxt.rej = rej;
    end else if (live && tok_i.phase == PH_STALE) begin
      if (age1 > win_s) begin
        mac_nxt = req.mac; ip_nxt = req.ip; time_nxt = req.now; cnt_nxt = 16'd1;
        tok_nxt.hit = 1'b1;
      end
    end
    if (fill.en && fill.idx == cell_idx) begin
      mac_nxt = req.mac; ip_nxt = req.ip; time_nxt = req.now; cnt_nxt = 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_r  <= '0;
      ip_r   <= '0;
      time_r <= '0;
      cnt_r  <= '0;
      tok_r  <= '0;
    end else begin
      mac_r  <= mac_nxt;
      ip_r   <= ip_nxt;
      time_r <= time_nxt;
      cnt_r  <= cnt_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_o = tok_r;
endmodule
`default_nettype wire

// File: hdl/repeat_request_filter_unit.sv
// Top level of the repeat request filter: cell chain, sequencer and ports.
// Each request is checked against a table of ENTRIES entries held in a row of
// cells. A scan token walks the row one cell per cycle: first a match pass
// (stops acting at the first IP or MAC hit), then, if nothing matched, a stale
// pass that recycles the first entry older than the window. If neither pass
// claims an entry, the request is written to the next free entry (or entry 0
// when full). A matching request ends after the match pass and any other one
// after the stale pass; each pass lasts as long as the token's walk down the
// chain. One request is in flight at a time; the verdict waits in an output
// register, and a new request is taken once it has been delivered. Config
// writes are always ready.
`default_nettype none
module repeat_request_filter_unit (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [111:0] in_tdata,   // mac_address[47:0], ip_address[79:48], now_seconds[111:80]
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [7:0]   out_tdata,  // verdict[0], zero pad
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [1:0]   cfg_index,
  input  wire  [15:0]  cfg_data
);
  import rrf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MATCH = 3'b010,
    ST_STALE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  cfg_t              cfg_r, cfg_nxt;
  tok_t              inj_r, inj_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              verdict_r, verdict_nxt;
  fill_t             fill;
  tok_t              chain [ENTRIES];
  tok_t              last;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      rrf_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (IDX_W'(g)),
        .used     (used_r),
        .req      (req_r),
        .cfg      (cfg_r),
        .fill     (fill),
        .tok_i    ((g == 0) ? inj_r : chain[(g == 0) ? 0 : g - 1]),
        .tok_o    (chain[g])
      );
    end
  endgenerate

  assign last      = chain[ENTRIES-1];
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE) && !out_vld_r;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'b0, verdict_r};

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    cfg_nxt     = cfg_r;
    inj_nxt     = '0;
    used_nxt    = used_r;
    out_vld_nxt = out_vld_r && !out_tready;
    verdict_nxt = verdict_r;
    fill        = '0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_WINDOW:  cfg_nxt.window  = cfg_data;
        CFG_IP_LIM:  cfg_nxt.ip_lim  = cfg_data;
        CFG_MAC_LIM: cfg_nxt.mac_lim = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          req_nxt.mac = in_tdata[47:0];
          req_nxt.ip  = in_tdata[79:48];
          req_nxt.now = in_tdata[111:80];
          inj_nxt     = '{vld: 1'b1, phase: PH_MATCH, hit: 1'b0, rej: 1'b0};
          state_nxt   = ST_MATCH;
        end
      end
      ST_MATCH: begin
        if (last.vld) begin
          if (last.hit) begin
            verdict_nxt = last.rej;
            out_vld_nxt = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            inj_nxt   = '{vld: 1'b1, phase: PH_STALE, hit: 1'b0, rej: 1'b0};
            state_nxt = ST_STALE;
          end
        end
      end
      ST_STALE: begin
        if (last.vld) begin
          // no stale entry: append, or overwrite entry 0 when full
          if (!last.hit) begin
            fill.en = 1'b1;
            if (used_r == USED_W'(ENTRIES)) begin
              fill.idx = '0;
            end else begin
              fill.idx = used_r[IDX_W-1:0];
              used_nxt = used_r + USED_W'(1);
            end
          end
          verdict_nxt = 1'b0;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cfg_r     <= '{window: WINDOW_RST, ip_lim: IP_LIM_RST, mac_lim: MAC_LIM_RST};
      inj_r     <= '0;
      used_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cfg_r     <= cfg_nxt;
      inj_r     <= inj_nxt;
      used_r    <= used_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    verdict_r <= verdict_nxt;
  end
endmodule
`default_nettype wire

// File: tb/rrf_checker.sv
// Request-table predictor and verdict checker for the repeat request filter.
`timescale 1ns / 100ps
module rrf_checker (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  input  wire          in_tready,
  input  wire  [111:0] in_tdata,
  input  wire          out_tvalid,
  input  wire          out_tready,
  input  wire  [7:0]   out_tdata,
  input  wire          cfg_valid,
  input  wire          cfg_ready,
  input  wire  [1:0]   cfg_index,
  input  wire  [15:0]  cfg_data,
  output int           fail_count,
  output int           verdicts_pending
);
  import rrf_pkg::*;

  logic [47:0] tbl_mac [ENTRIES];
  logic [31:0] tbl_ip [ENTRIES];
  logic [31:0] tbl_time [ENTRIES];
  logic [15:0] tbl_count [ENTRIES];
  int          tbl_used;
  cfg_t        regs;
  logic [7:0]  verdict_q[$];

  function automatic logic signed [33:0] age_at(logic [31:0] now, int k);
    return $signed({2'b00, now}) - $signed({2'b00, tbl_time[k]});
  endfunction

  function automatic void put_entry(int k, logic [47:0] mac, logic [31:0] ip,
                                    logic [31:0] now);
    tbl_mac[k] = mac; tbl_ip[k] = ip; tbl_time[k] = now; tbl_count[k] = 16'd1;
  endfunction

  function automatic void wipe_entry(int k);
    tbl_mac[k] = '0; tbl_ip[k] = '0; tbl_time[k] = '0; tbl_count[k] = '0;
  endfunction

  // Returns the verdict for one request and updates the table.
  function automatic logic judge_request(req_t r);
    logic signed [33:0] win;
    bit found;
    win = $signed({18'd0, regs.window});
    found = 0;
    for (int k = 0; k < tbl_used && !found; k++) begin
      if (r.ip != 0 && r.ip == tbl_ip[k]) begin
        if (age_at(r.now, k) < win) begin
          tbl_count[k] = tbl_count[k] + 16'd1;
          if (tbl_count[k] > regs.ip_lim) return 1'b1;
          tbl_time[k] = r.now;
        end else begin
          wipe_entry(k);
        end
        found = 1;
      end
      if (r.mac != 0 && r.mac == tbl_mac[k]) begin
        if (age_at(r.now, k) < win) begin
          tbl_time[k] = r.now;
          tbl_count[k] = tbl_count[k] + 16'd1;
          if (tbl_count[k] > regs.mac_lim) return 1'b1;
        end else begin
          wipe_entry(k);
        end
        found = 1;
      end
    end
    if (found) return 1'b0;
    for (int k = 0; k < tbl_used; k++) begin
      if (age_at(r.now, k) > win) begin
        put_entry(k, r.mac, r.ip, r.now);
        return 1'b0;
      end
    end
    if (tbl_used >= ENTRIES) begin
      put_entry(0, r.mac, r.ip, r.now);
    end else begin
      put_entry(tbl_used, r.mac, r.ip, r.now);
      tbl_used++;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    req_t       req;
    if (!rst_n) begin
      for (int k = 0; k < ENTRIES; k++) wipe_entry(k);
      tbl_used = 0;
      regs = '{window: WINDOW_RST, ip_lim: IP_LIM_RST, mac_lim: MAC_LIM_RST};
      verdict_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW:  regs.window  = cfg_data;
          CFG_IP_LIM:  regs.ip_lim  = cfg_data;
          CFG_MAC_LIM: regs.mac_lim = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: verdict %0h with no request outstanding", $realtime, out_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: verdict mismatch: expected %0h, got %0h",
                       $realtime, want, out_tdata);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        // mac in the low bits, then ip, then time
        req.mac = in_tdata[47:0];
        req.ip  = in_tdata[79:48];
        req.now = in_tdata[111:80];
        verdict_q.push_back({7'd0, judge_request(req)});
      end
    end
    verdicts_pending = verdict_q.size();
  end
endmodule

// File: tb/tb_repeat_request_filter_unit.sv
// Stimulus and verdict for the repeat request filter testbench.
`timescale 1ns / 100ps
module tb_repeat_request_filter_unit;
  import rrf_pkg::*;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;   // mac_address, ip_address, now_seconds from bit 0 up
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [7:0]   out_tdata;       // verdict, zero pad
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;
  int           fail_count, verdicts_pending;

  int  send_idle_pct, recv_idle_pct;
  int  hold_off = 0;           // cycles for a long receiver stall
  logic [31:0] clock_now = 0;  // requests carry a mostly rising time

  // small pools so that addresses repeat often
  logic [47:0] mac_pool [8];
  logic [31:0] ip_pool [8];

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  repeat_request_filter_unit dut (.*);

  rrf_checker chk (.*);

  initial begin
    #80ms;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 0;
      hold_off <= hold_off - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // valid drops at the negedge after the accept; the next request waits for a later negedge
  task automatic send_request(logic [47:0] mac, logic [31:0] ip, logic [31:0] now);
    do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    in_tdata  <= {now, ip, mac};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // wait for all verdicts, then a margin past the block's scan time
  task automatic drain;
    while (verdicts_pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic random_request;
    logic [47:0] mac;
    logic [31:0] ip;
    int r;
    r = $urandom_range(99);
    if (r < 3) clock_now = clock_now - $urandom_range(5);  // time running backwards
    else if (r < 10) clock_now = clock_now + $urandom_range(40);
    else clock_now = clock_now + $urandom_range(2);
    mac = $urandom_range(9) == 0 ? 48'd0 :
          $urandom_range(4) == 0 ? 48'({$urandom, $urandom}) : mac_pool[$urandom_range(7)];
    ip  = $urandom_range(9) == 0 ? 32'd0 :
          $urandom_range(4) == 0 ? $urandom : ip_pool[$urandom_range(7)];
    send_request(mac, ip, clock_now);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      mac_pool[i] = 48'({$urandom, $urandom});
      ip_pool[i]  = $urandom;
    end
    send_idle_pct = 23;
    recv_idle_pct = 48;
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: reset limits, field extremes, zero addresses, wraps in time
    send_request('1, '1, '1);
    send_request('1, '1, '1);
    send_request('1, '1, '1);
    send_request('1, 32'd5, 32'd0);          // time backwards, MAC hit
    send_request(48'd0, 32'd0, 32'd3);
    send_request(48'd0, 32'd0, 32'd3);
    send_request(48'd7, 32'd0, 32'd100);
    send_request(48'd0, 32'd9, 32'd100);
    send_request(48'd7, 32'd9, 32'd105);     // IP test then MAC test on different entries
    send_request(48'd7, 32'd9, 32'd200);     // match outside the window clears
    send_request(48'd8, 32'd10, 32'd400);    // stale slot reuse
    for (int i = 0; i < 8; i++) send_request(48'd7, 32'd0, 32'd401);  // MAC limit
    drain();

    // extreme settings, including a window of zero
    write_reg(CFG_WINDOW, 16'd0);
    write_reg(CFG_IP_LIM, 16'd1);
    write_reg(CFG_MAC_LIM, 16'd1);
    for (int i = 0; i < 6; i++) send_request(48'd7, 32'd9, 32'd401 - i);
    drain();
    write_reg(CFG_WINDOW, 16'hFFFF);
    write_reg(CFG_IP_LIM, 16'hFFFF);
    write_reg(CFG_MAC_LIM, 16'hFFFF);

    // table fills past ENTRIES with distinct requesters; long receiver stall
    clock_now = 1000;
    hold_off = 2000;
    for (int i = 0; i < 140; i++)
      send_request(48'({$urandom, $urandom}), $urandom, clock_now);
    for (int i = 0; i < 60; i++) random_request();
    drain();

    // sender idles more than the receiver
    write_reg(CFG_WINDOW, 16'd20);
    write_reg(CFG_IP_LIM, 16'd3);
    write_reg(CFG_MAC_LIM, 16'd5);
    send_idle_pct = 48;
    recv_idle_pct = 23;
    for (int i = 0; i < 250; i++) random_request();
    drain();

    // reset values again, no idling
    write_reg(CFG_WINDOW, WINDOW_RST);
    write_reg(CFG_IP_LIM, IP_LIM_RST);
    write_reg(CFG_MAC_LIM, MAC_LIM_RST);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 250; i++) random_request();
    drain();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/rrf_pkg.sv
hdl/rrf_cell.sv
hdl/repeat_request_filter_unit.sv
tb/rrf_checker.sv
tb/tb_repeat_request_filter_unit.sv
